/* rtl/rc3_pkg.sv */
package rc3_pkg;

    localparam int MaxWidthDef = 2048;
    localparam int FracBitsDef = 8;
    localparam int CoefWidthDef = 16;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 48;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KROW_BELOW  = 3'd0,
        REG_KROW_CENTER = 3'd1,
        REG_KROW_ABOVE  = 3'd2,
        REG_BIAS        = 3'd3,
        REG_WIDTH       = 3'd4,
        REG_HEIGHT      = 3'd5
    } t_reg_idx;

    localparam logic [47:0] KrowCenterRst = 48'h000001000000;
    localparam logic [11:0] WidthRst = 12'd640;
    localparam logic [15:0] HeightRst = 16'd480;
    localparam logic [7:0] PixMax = 8'd255;

    // handed down the channel-cell chain
    typedef struct packed {
        logic       filt;
        logic       valid;
    } t_cell_ctl;

endpackage

/* rtl/rc3_chan_cell.sv */
// One channel of the MAC chain: each stage adds one row (three taps) to the
// partial sum it hands to the next cell. Rounding and clamping follow the
// last cell in the top level.
module rc3_chan_cell #(
    parameter int COEF_WIDTH = rc3_pkg::CoefWidthDef,
    parameter int ACC_W = 32
) (
    input  logic                  i_clk,
    input  logic signed [COEF_WIDTH-1:0] i_k0,
    input  logic signed [COEF_WIDTH-1:0] i_k1,
    input  logic signed [COEF_WIDTH-1:0] i_k2,
    input  logic [7:0]            i_p0,
    input  logic [7:0]            i_p1,
    input  logic [7:0]            i_p2,
    input  logic signed [ACC_W-1:0] i_sum,
    output logic signed [ACC_W-1:0] o_sum
);
    logic signed [ACC_W-1:0] n_sum;
    logic signed [ACC_W-1:0] r_sum;

    always_comb begin
        n_sum = i_sum
            + (ACC_W'(i_k0) * ACC_W'($signed({1'b0, i_p0})))
            + (ACC_W'(i_k1) * ACC_W'($signed({1'b0, i_p1})))
            + (ACC_W'(i_k2) * ACC_W'($signed({1'b0, i_p2})));
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;
endmodule

/* rtl/rc3_line_mem.sv */
module rc3_line_mem #(
    parameter int DEPTH = rc3_pkg::MaxWidthDef,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/rgba_conv3x3_fixed_point.sv */
// 3x3 convolution on 4-channel 8-bit pixels in raster order. One pixel word
// is accepted per clock while the output queue has room; results lag by one
// row plus one column and flow through a 4-stage pipeline (line-store read,
// then one MAC cell per kernel row for each channel) into a small output
// queue. Interior rows emit one word per input; the last row emits two per
// input (up to four on the final pixel), so input is held off while the
// queue drains there. Border pixels are copied. Line stores need no clearing
// after reset. The user must write sizes only while idle; it is unchecked.
module rgba_conv3x3_fixed_point #(
    parameter int MAX_WIDTH = rc3_pkg::MaxWidthDef,
    parameter int FRAC_BITS = rc3_pkg::FracBitsDef,
    parameter int COEF_WIDTH = rc3_pkg::CoefWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [rc3_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [rc3_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_channel_0..3, 8 bits each from bit 0
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_channel_0..3, 8 bits each from bit 0
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // end_of_image
    output logic        m_axis_tuser
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int ACC_W = COEF_WIDTH + 15;
    localparam int QD = 8;
    localparam int QAW = 3;

    // ---------------- configuration
    logic [47:0] r_kb, r_kc, r_ka;
    logic [23:0] r_bias;
    logic [11:0] r_wcfg;
    logic [15:0] r_hcfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kb <= '0;
            r_kc <= rc3_pkg::KrowCenterRst;
            r_ka <= '0;
            r_bias <= '0;
            r_wcfg <= rc3_pkg::WidthRst;
            r_hcfg <= rc3_pkg::HeightRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rc3_pkg::REG_KROW_BELOW:  r_kb <= i_cfg_data;
                rc3_pkg::REG_KROW_CENTER: r_kc <= i_cfg_data;
                rc3_pkg::REG_KROW_ABOVE:  r_ka <= i_cfg_data;
                rc3_pkg::REG_BIAS:        r_bias <= i_cfg_data[23:0];
                rc3_pkg::REG_WIDTH:       r_wcfg <= i_cfg_data[11:0];
                rc3_pkg::REG_HEIGHT:      r_hcfg <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [13:0] w_eff;
    logic [15:0] h_eff;
    always_comb begin
        w_eff = {2'b0, r_wcfg};
        if (w_eff < 14'd3) w_eff = 14'd3;
        if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
        h_eff = (r_hcfg < 16'd3) ? 16'd3 : r_hcfg;
    end

    // ---------------- stage 0: positions, store read
    logic [13:0] r_col;
    logic [15:0] r_row;
    logic        acc_in;
    logic        lastc, lastr;
    logic [AW-1:0] idx;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign lastc = (r_col >= w_eff - 14'd1);
    assign lastr = (r_row >= h_eff - 16'd1);
    assign idx = (r_col >= 14'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : r_col[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc_in) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? 16'd0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + 14'd1;
            end
        end
    end

    // both line stores in one 64-bit word: {prev2, prev}
    logic [63:0] mem_rd;
    logic        r1_v;
    logic [AW-1:0] r1_idx;
    logic [31:0] r1_cur;
    logic [13:0] r1_col;
    logic        r1_lastc, r1_lastr, r1_row1, r1_row0;

    // read-after-write of the same index is impossible: consecutive inputs
    // use different columns since width is at least 3
    rc3_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (r1_v),
        .i_waddr(r1_idx),
        .i_wdata({mem_rd[31:0], r1_cur}),
        .i_re   (acc_in),
        .i_raddr(idx),
        .o_rdata(mem_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= acc_in;
        end
        if (acc_in) begin
            r1_idx <= idx;
            r1_cur <= s_axis_tdata;
            r1_col <= r_col;
            r1_lastc <= lastc;
            r1_lastr <= lastr;
            r1_row1 <= (r_row == 16'd1);
            r1_row0 <= (r_row == 16'd0);
        end
    end

    // ---------------- stage 1: window update, decide emissions
    logic [31:0] r_win [6];
    logic [31:0] up, mid;
    assign up = mem_rd[63:32];
    assign mid = mem_rd[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (r1_v) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up;
            r_win[4] <= mid;
            r_win[5] <= r1_cur;
        end
    end

    logic emit_main, filt;
    logic [13:0] xc;
    assign xc = r1_col - 14'd1;
    assign emit_main = !r1_row0 && (r1_col != 14'd0);
    assign filt = emit_main && !r1_row1 && (xc != 14'd0) && (xc < w_eff - 14'd1);

    // pipeline payload: 4 slots; slot0 may be filtered
    typedef struct packed {
        logic [3:0]  v;
        logic [3:0]  last;
        logic [3:0]  eoi;
        logic [31:0] c0, c1, c2, c3;
        logic        filt;
    } t_emit;

    t_emit e1;
    always_comb begin
        logic [2:0] n;
        logic [31:0] pv [4];
        n = '0;
        for (int i = 0; i < 4; i++) pv[i] = '0;
        if (emit_main) begin
            pv[n[1:0]] = r_win[4]; n = n + 3'd1;
            if (r1_lastr) begin pv[n[1:0]] = r_win[5]; n = n + 3'd1; end
        end
        if (!r1_row0 && r1_lastc) begin
            pv[n[1:0]] = mid; n = n + 3'd1;
            if (r1_lastr) begin pv[n[1:0]] = r1_cur; n = n + 3'd1; end
        end
        e1.v = '0; e1.last = '0; e1.eoi = '0;
        for (int i = 0; i < 4; i++) e1.v[i] = (3'(i) < n);
        if (n != 3'd0) begin
            e1.last[n[1:0] - 2'd1] = 1'b1;
            e1.eoi[n[1:0] - 2'd1] = r1_lastr && r1_lastc;
        end
        e1.c0 = pv[0]; e1.c1 = pv[1]; e1.c2 = pv[2]; e1.c3 = pv[3];
        e1.filt = filt && r1_v;
        if (!r1_v) e1.v = '0;
    end

    // taps for the filter: above row win0,win3,up; centre win1,win4,mid;
    // below win2,win5,cur
    logic [31:0] ta [3], tc [3], tb [3];
    always_comb begin
        ta[0] = r_win[0]; ta[1] = r_win[3]; ta[2] = up;
        tc[0] = r_win[1]; tc[1] = r_win[4]; tc[2] = mid;
        tb[0] = r_win[2]; tb[1] = r_win[5]; tb[2] = r1_cur;
    end

    // registered taps for later cells
    logic [31:0] r2_tc [3], r2_tb [3], r3_tb [3];
    t_emit r2_e, r3_e, r4_e;
    rc3_pkg::t_cell_ctl r2_ctl, r3_ctl, r4_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0; r3_ctl <= '0; r4_ctl <= '0;
        end else begin
            r2_ctl <= '{filt: e1.filt, valid: r1_v};
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
        r2_e <= e1; r3_e <= r2_e; r4_e <= r3_e;
        r2_tc <= tc; r2_tb <= tb; r3_tb <= r2_tb;
    end

    logic signed [ACC_W-1:0] bias_init;
    assign bias_init = ACC_W'($signed(r_bias)) + ACC_W'(1 << (FRAC_BITS - 1));

    logic [31:0] filt_pix;
    for (genvar ch = 0; ch < 4; ch++) begin : g_ch
        logic signed [ACC_W-1:0] s1, s2, s3;
        logic signed [ACC_W-1:0] q;
        rc3_chan_cell #(.COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W))
        u_above (
            .i_clk(i_clk),
            .i_k0(r_ka[COEF_WIDTH-1:0]), .i_k1(r_ka[16+:COEF_WIDTH]),
            .i_k2(r_ka[32+:COEF_WIDTH]),
            .i_p0(ta[0][8*ch+:8]), .i_p1(ta[1][8*ch+:8]), .i_p2(ta[2][8*ch+:8]),
            .i_sum(bias_init), .o_sum(s1)
        );
        rc3_chan_cell #(.COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W))
        u_center (
            .i_clk(i_clk),
            .i_k0(r_kc[COEF_WIDTH-1:0]), .i_k1(r_kc[16+:COEF_WIDTH]),
            .i_k2(r_kc[32+:COEF_WIDTH]),
            .i_p0(r2_tc[0][8*ch+:8]), .i_p1(r2_tc[1][8*ch+:8]),
            .i_p2(r2_tc[2][8*ch+:8]),
            .i_sum(s1), .o_sum(s2)
        );
        rc3_chan_cell #(.COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W))
        u_below (
            .i_clk(i_clk),
            .i_k0(r_kb[COEF_WIDTH-1:0]), .i_k1(r_kb[16+:COEF_WIDTH]),
            .i_k2(r_kb[32+:COEF_WIDTH]),
            .i_p0(r3_tb[0][8*ch+:8]), .i_p1(r3_tb[1][8*ch+:8]),
            .i_p2(r3_tb[2][8*ch+:8]),
            .i_sum(s2), .o_sum(s3)
        );
        assign q = s3 >>> FRAC_BITS;
        assign filt_pix[8*ch+:8] = (q < 0) ? 8'd0 :
            (q > ACC_W'(rc3_pkg::PixMax)) ? rc3_pkg::PixMax : q[7:0];
    end

    // ---------------- output queue
    logic [33:0] r_q [QD];
    logic [QAW:0] r_wp, r_rp;
    logic [QAW:0] fill;
    assign fill = r_wp - r_rp;

    logic [33:0] ent [4];
    logic [2:0]  n_new;
    always_comb begin
        ent[0] = {r4_e.eoi[0], r4_e.last[0], r4_ctl.filt ? filt_pix : r4_e.c0};
        ent[1] = {r4_e.eoi[1], r4_e.last[1], r4_e.c1};
        ent[2] = {r4_e.eoi[2], r4_e.last[2], r4_e.c2};
        ent[3] = {r4_e.eoi[3], r4_e.last[3], r4_e.c3};
        n_new = '0;
        if (r4_ctl.valid) begin
            for (int i = 0; i < 4; i++) n_new = n_new + 3'(r4_e.v[i]);
        end
    end

    logic out_acc;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= r_wp + (QAW+1)'(n_new);
            if (out_acc) r_rp <= r_rp + 1'b1;
        end
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n_new) r_q[QAW'(r_wp + (QAW+1)'(i))] <= ent[i];
        end
    end

    assign m_axis_tvalid = (fill != '0);
    assign m_axis_tdata = r_q[r_rp[QAW-1:0]][31:0];
    assign m_axis_tlast = r_q[r_rp[QAW-1:0]][32];
    assign m_axis_tuser = r_q[r_rp[QAW-1:0]][33];

    // words owed to the queue: exact count per stage in flight, plus the
    // worst case of the word being accepted (four only on the last row)
    logic [QAW+3:0] pend;
    always_comb begin
        pend = (QAW+4)'(fill);
        if (r1_v) pend = pend + (QAW+4)'($countones(e1.v));
        if (r2_ctl.valid) pend = pend + (QAW+4)'($countones(r2_e.v));
        if (r3_ctl.valid) pend = pend + (QAW+4)'($countones(r3_e.v));
        if (r4_ctl.valid) pend = pend + (QAW+4)'($countones(r4_e.v));
    end
    assign s_axis_tready = i_rst_n &&
        (pend + (QAW+4)'(lastr ? 4 : 2) <= (QAW+4)'(QD));

    assert property (@(posedge i_clk) disable iff (!i_rst_n) fill <= (QAW+1)'(QD))
        else $error("output queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_ctl.filt |-> r4_ctl.valid && r4_e.v[0])
        else $error("filtered result without a slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_ctl.valid |-> ((r4_e.v & (r4_e.v + 4'd1)) == 4'd0))
        else $error("result slots not packed from slot 0");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of image without last");
endmodule
